// ----- rtl/pcs_pkg.sv -----
package pcs_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam logic [0:0] OP_ADMIT = 1'b0;
  localparam logic [0:0] OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_TRANS  = 2'd0;
  localparam logic [1:0] KIND_SUMM   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_FULL = 2'd1;
  localparam logic [1:0] CAUSE_ZERO = 2'd2;

  typedef enum logic [2:0] {
    PH_NEW   = 3'd0,
    PH_READY = 3'd1,
    PH_RUN   = 3'd2,
    PH_WAIT  = 3'd3,
    PH_TERM  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REC_ADMIT,
    REC_REJECT,
    REC_WAKE,
    REC_DISP,
    REC_RUN,
    REC_SUM
  } rec_t;

  typedef struct packed {
    logic take_in;
    logic scan_clr;
    logic scan_step;
    logic scan_disp;
    logic wake_commit;
    logic disp_commit;
    logic admit_commit;
    logic run_commit;
    logic load_out;
    rec_t rec;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic run_idle;
    logic run_evt;
    logic admit_ok;
  } sts_t;

endpackage

// ----- rtl/pcs_ctrl.sv -----
module pcs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pcs_pkg::sts_t sts,
  output pcs_pkg::cmd_t cmd
);
  import pcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADMIT, S_WSCAN, S_WDEC, S_DSCAN, S_DDEC, S_RUN, S_SUM, S_EMIT
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  always_comb begin
    cmd       = '0;
    cmd.rec   = REC_SUM;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in  = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = (in_opcode == OP_ADMIT) ? S_ADMIT : S_WSCAN;
        end
      end
      S_ADMIT: begin
        cmd.load_out     = 1'b1;
        cmd.last         = 1'b1;
        cmd.rec          = sts.admit_ok ? REC_ADMIT : REC_REJECT;
        cmd.admit_commit = sts.admit_ok;
        ret_nxt          = S_IDLE;
        state_nxt        = S_EMIT;
      end
      S_WSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_WDEC;
      end
      S_WDEC: begin
        cmd.scan_clr = 1'b1;
        if (sts.found) begin
          cmd.wake_commit = 1'b1;
          cmd.load_out    = 1'b1;
          cmd.rec         = REC_WAKE;
          ret_nxt         = S_WSCAN;
          state_nxt       = S_EMIT;
        end else if (sts.run_idle) begin
          state_nxt = S_DSCAN;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_DSCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_disp = 1'b1;
        if (sts.scan_last) state_nxt = S_DDEC;
      end
      S_DDEC: begin
        if (sts.found) begin
          cmd.disp_commit = 1'b1;
          cmd.load_out    = 1'b1;
          cmd.rec         = REC_DISP;
          ret_nxt         = S_RUN;
          state_nxt       = S_EMIT;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.run_commit = 1'b1;
        if (sts.run_evt) begin
          cmd.load_out = 1'b1;
          cmd.rec      = REC_RUN;
          ret_nxt      = S_SUM;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.load_out = 1'b1;
        cmd.last     = 1'b1;
        cmd.rec      = REC_SUM;
        ret_nxt      = S_IDLE;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  a_emit_ret: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> ret_r != S_EMIT)
    else $error("emit state returns to itself");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && cmd.last |=> state_r == S_EMIT && ret_r == S_IDLE)
    else $error("final request does not end the item");
  a_wake_rescan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wake_commit |=> ret_r == S_WSCAN)
    else $error("wakeup not followed by rescan");
endmodule

// ----- rtl/pcs_dpath.sv -----
module pcs_dpath #(
  parameter int MAX_PROCS = pcs_pkg::MAX_PROCS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_pid,
  input  logic [15:0]   in_burst,
  input  logic [15:0]   in_io_every,
  input  logic [15:0]   in_io_length,
  input  pcs_pkg::cmd_t cmd,
  output pcs_pkg::sts_t sts,
  output logic [1:0]    out_kind,
  output logic [31:0]   out_event_time,
  output logic [7:0]    out_proc_id,
  output logic [2:0]    out_from_state,
  output logic [2:0]    out_to_state,
  output logic [1:0]    out_reject_cause,
  output logic          out_cpu_idle,
  output logic          out_finished,
  output logic          out_last
);
  import pcs_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_PROCS - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_PROCS);

  logic [7:0]  pid_r    [MAX_PROCS];
  phase_t      phase_r  [MAX_PROCS];
  logic [15:0] rem_r    [MAX_PROCS];
  logic [15:0] period_r [MAX_PROCS];
  logic [15:0] cd_r     [MAX_PROCS];
  logic [15:0] iow_r    [MAX_PROCS];
  logic [31:0] wake_r   [MAX_PROCS];
  logic [31:0] ws_r     [MAX_PROCS];

  logic [7:0]    ipid_r;
  logic [15:0]   iburst_r, ievery_r, ilen_r;
  logic [CW-1:0] used_cnt_r, term_cnt_r;
  logic [31:0]   now_r;
  logic [IW-1:0] run_r, idx_r, best_r;
  logic          run_idle_r, found_r;
  logic [31:0]   best_key_r;

  logic          cand;
  logic [31:0]   key;
  logic [15:0]   rem1, cd1, cd_new;
  logic          hit, to_wait, to_term;
  logic [IW-1:0] free_idx;
  logic [31:0]   t1;

  assign free_idx = used_cnt_r[IW-1:0];
  assign t1       = now_r + 32'd1;

  always_comb begin
    if (cmd.scan_disp) begin
      key  = {24'd0, pid_r[idx_r]};
      cand = phase_r[idx_r] == PH_READY;
    end else begin
      key  = ws_r[idx_r];
      cand = (phase_r[idx_r] == PH_WAIT) && (wake_r[idx_r] == now_r);
    end
    cand = cand && (CW'(idx_r) < used_cnt_r) && (!found_r || key < best_key_r);
  end

  always_comb begin
    rem1 = rem_r[run_r] - 16'd1;
    cd1  = cd_r[run_r] - 16'd1;
    hit  = (period_r[run_r] != 16'd0) && (cd1 == 16'd0);
    if (period_r[run_r] == 16'd0) cd_new = cd_r[run_r];
    else if (hit)                 cd_new = period_r[run_r];
    else                          cd_new = cd1;
    to_wait = hit && (iow_r[run_r] != 16'd0) && (rem1 != 16'd0);
    to_term = !to_wait && (rem1 == 16'd0);
  end

  always_comb begin
    sts.scan_last = (idx_r == IDX_LAST);
    sts.found     = found_r;
    sts.run_idle  = run_idle_r;
    sts.run_evt   = !run_idle_r && (to_wait || to_term);
    sts.admit_ok  = (iburst_r != 16'd0) && (used_cnt_r < CNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      ipid_r   <= in_pid;
      iburst_r <= in_burst;
      ievery_r <= in_io_every;
      ilen_r   <= in_io_length;
    end
    if (cmd.scan_step && cand) begin
      best_r     <= idx_r;
      best_key_r <= key;
    end
    if (cmd.admit_commit) begin
      pid_r[free_idx]    <= ipid_r;
      phase_r[free_idx]  <= PH_READY;
      rem_r[free_idx]    <= iburst_r;
      period_r[free_idx] <= ievery_r;
      cd_r[free_idx]     <= ievery_r;
      iow_r[free_idx]    <= ilen_r;
      wake_r[free_idx]   <= 32'd0;
      ws_r[free_idx]     <= 32'd0;
    end
    if (cmd.wake_commit) phase_r[best_r] <= PH_READY;
    if (cmd.disp_commit) phase_r[best_r] <= PH_RUN;
    if (cmd.run_commit && !run_idle_r) begin
      rem_r[run_r] <= rem1;
      cd_r[run_r]  <= cd_new;
      if (to_wait) begin
        phase_r[run_r] <= PH_WAIT;
        ws_r[run_r]    <= t1;
        wake_r[run_r]  <= t1 + {16'd0, iow_r[run_r]};
      end else if (to_term) begin
        phase_r[run_r] <= PH_TERM;
      end
    end
    if (cmd.load_out) begin
      out_last         <= cmd.last;
      out_kind         <= KIND_TRANS;
      out_event_time   <= now_r;
      out_reject_cause <= CAUSE_NONE;
      out_cpu_idle     <= 1'b0;
      out_finished     <= 1'b0;
      out_from_state   <= PH_NEW;
      out_to_state     <= PH_NEW;
      out_proc_id      <= pid_r[best_r];
      unique case (cmd.rec)
        REC_ADMIT: begin
          out_proc_id    <= ipid_r;
          out_to_state   <= PH_READY;
        end
        REC_REJECT: begin
          out_kind         <= KIND_REJECT;
          out_proc_id      <= ipid_r;
          out_reject_cause <= (iburst_r == 16'd0) ? CAUSE_ZERO : CAUSE_FULL;
        end
        REC_WAKE: begin
          out_from_state <= PH_WAIT;
          out_to_state   <= PH_READY;
        end
        REC_DISP: begin
          out_from_state <= PH_READY;
          out_to_state   <= PH_RUN;
        end
        REC_RUN: begin
          out_event_time <= t1;
          out_proc_id    <= pid_r[run_r];
          out_from_state <= PH_RUN;
          out_to_state   <= to_wait ? PH_WAIT : PH_TERM;
        end
        REC_SUM: begin
          out_kind     <= KIND_SUMM;
          out_proc_id  <= run_idle_r ? 8'd0 : pid_r[run_r];
          out_cpu_idle <= run_idle_r;
          out_finished <= (used_cnt_r != '0) && (term_cnt_r == used_cnt_r);
        end
        default: out_kind <= KIND_TRANS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_cnt_r <= '0;
      term_cnt_r <= '0;
      now_r      <= '0;
      run_r      <= '0;
      run_idle_r <= 1'b1;
      idx_r      <= '0;
      found_r    <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        idx_r <= sts.scan_last ? '0 : idx_r + IW'(1);
        if (cand) found_r <= 1'b1;
      end
      if (cmd.admit_commit) used_cnt_r <= used_cnt_r + CW'(1);
      if (cmd.disp_commit) begin
        run_r      <= best_r;
        run_idle_r <= 1'b0;
      end
      if (cmd.run_commit) begin
        now_r <= t1;
        if (!run_idle_r && (to_wait || to_term)) run_idle_r <= 1'b1;
        if (!run_idle_r && to_term) term_cnt_r <= term_cnt_r + CW'(1);
      end
    end
  end

  a_term_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    term_cnt_r <= used_cnt_r)
    else $error("more terminated than admitted");
  a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !run_idle_r |-> CW'(run_r) < used_cnt_r)
    else $error("running slot not in use");
  a_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !run_idle_r |-> phase_r[run_r] == PH_RUN)
    else $error("running slot not in run phase");
endmodule

// ----- rtl/priority_cpu_scheduler_with_io.sv -----
// An admit request is checked in the admit state; its result then waits in the emit state.
// A tick scans every slot for a due wakeup, reading one table entry per cycle, and emits
// each wakeup before it rescans; if the CPU is idle it then scans for the lowest-pid ready
// process to dispatch, advances time by one and ends with a summary; output stalls hold it.
// One request is in work at a time; the next is taken in the cycle after the final result.
// Synchronous active-low reset empties the table, sets time to zero and idles the CPU.
module priority_cpu_scheduler_with_io #(
  parameter int MAX_PROCS = pcs_pkg::MAX_PROCS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_pid,
  input  logic [15:0] in_burst,
  input  logic [15:0] in_io_every,
  input  logic [15:0] in_io_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_event_time,
  output logic [7:0]  out_proc_id,
  output logic [2:0]  out_from_state,
  output logic [2:0]  out_to_state,
  output logic [1:0]  out_reject_cause,
  output logic        out_cpu_idle,
  output logic        out_finished,
  output logic        out_last
);
  import pcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcs_dpath #(.MAX_PROCS(MAX_PROCS)) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_pid           (in_pid),
    .in_burst         (in_burst),
    .in_io_every      (in_io_every),
    .in_io_length     (in_io_length),
    .cmd              (cmd),
    .sts              (sts),
    .out_kind         (out_kind),
    .out_event_time   (out_event_time),
    .out_proc_id      (out_proc_id),
    .out_from_state   (out_from_state),
    .out_to_state     (out_to_state),
    .out_reject_cause (out_reject_cause),
    .out_cpu_idle     (out_cpu_idle),
    .out_finished     (out_finished),
    .out_last         (out_last)
  );
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pcs_pkg::*;

  localparam int NSLOT = MAX_PROCS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic        opcode;
    logic [7:0]  pid;
    logic [15:0] burst;
    logic [15:0] io_every;
    logic [15:0] io_length;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] event_time;
    logic [7:0]  proc_id;
    logic [2:0]  from_state;
    logic [2:0]  to_state;
    logic [1:0]  reject_cause;
    logic        cpu_idle;
    logic        finished;
    logic        last;
  } record_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_pid;
  logic [15:0] in_burst;
  logic [15:0] in_io_every;
  logic [15:0] in_io_length;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [31:0] out_event_time;
  logic [7:0]  out_proc_id;
  logic [2:0]  out_from_state;
  logic [2:0]  out_to_state;
  logic [1:0]  out_reject_cause;
  logic        out_cpu_idle;
  logic        out_finished;
  logic        out_last;

  priority_cpu_scheduler_with_io u_top (.*);

  // Scheduler shadow state.
  logic        sh_used [NSLOT];
  logic [7:0]  sh_pid [NSLOT];
  phase_t      sh_phase [NSLOT];
  logic [15:0] sh_remain [NSLOT];
  logic [15:0] sh_period [NSLOT];
  logic [15:0] sh_count [NSLOT];
  logic [15:0] sh_iolen [NSLOT];
  logic [31:0] sh_wake [NSLOT];
  logic [31:0] sh_wstart [NSLOT];
  logic [31:0] sh_now;
  int          sh_running;

  request_t pending_requests[$];
  record_t  expected_records[$];
  int       mismatches;
  int       records_seen;
  int       ticks_sent;
  int       admits_sent;
  int       rejects_seen;
  int       waits_seen;
  bit       stim_done;
  int       idle_cycles;

  function automatic record_t mk_rec(logic [1:0] k, logic [31:0] t, logic [7:0] p,
                                     logic [2:0] f, logic [2:0] to, logic [1:0] c,
                                     logic idle, logic done);
    record_t r;
    r.kind = k; r.event_time = t; r.proc_id = p; r.from_state = f;
    r.to_state = to; r.reject_cause = c; r.cpu_idle = idle; r.finished = done;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic schedule_request(input request_t rq);
    record_t recs[$];
    int free_idx;
    int best;
    bit woke [NSLOT];
    bit any;
    bit done;
    bit hit;
    int s;
    logic [31:0] t1;
    if (rq.opcode == OP_ADMIT) begin
      free_idx = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!sh_used[i] && free_idx < 0) free_idx = i;
      end
      if (rq.burst == 0) begin
        recs = {recs, mk_rec(KIND_REJECT, sh_now, rq.pid, PH_NEW, PH_NEW, CAUSE_ZERO, 0, 0)};
      end else if (free_idx < 0) begin
        recs = {recs, mk_rec(KIND_REJECT, sh_now, rq.pid, PH_NEW, PH_NEW, CAUSE_FULL, 0, 0)};
      end else begin
        sh_used[free_idx] = 1'b1;
        sh_pid[free_idx] = rq.pid;
        sh_phase[free_idx] = PH_READY;
        sh_remain[free_idx] = rq.burst;
        sh_period[free_idx] = rq.io_every;
        sh_count[free_idx] = rq.io_every;
        sh_iolen[free_idx] = rq.io_length;
        sh_wake[free_idx] = '0;
        sh_wstart[free_idx] = '0;
        recs = {recs, mk_rec(KIND_TRANS, sh_now, rq.pid, PH_NEW, PH_READY, CAUSE_NONE, 0, 0)};
      end
    end else begin
      foreach (woke[i]) woke[i] = 0;
      forever begin
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (sh_used[i] && !woke[i] && sh_phase[i] == PH_WAIT && sh_wake[i] == sh_now)
            if (best < 0 || sh_wstart[i] < sh_wstart[best]) best = i;
        end
        if (best < 0) break;
        woke[best] = 1;
        sh_phase[best] = PH_READY;
        recs = {recs, mk_rec(KIND_TRANS, sh_now, sh_pid[best], PH_WAIT, PH_READY,
                             CAUSE_NONE, 0, 0)};
      end
      if (sh_running >= NSLOT) begin
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (sh_used[i] && sh_phase[i] == PH_READY)
            if (best < 0 || sh_pid[i] < sh_pid[best]) best = i;
        end
        if (best >= 0) begin
          sh_phase[best] = PH_RUN;
          sh_running = best;
          recs = {recs, mk_rec(KIND_TRANS, sh_now, sh_pid[best], PH_READY, PH_RUN,
                               CAUSE_NONE, 0, 0)};
        end
      end
      if (sh_running < NSLOT) begin
        s = sh_running;
        hit = 0;
        t1 = sh_now + 1;
        sh_remain[s] = sh_remain[s] - 1;
        if (sh_period[s] != 0) begin
          sh_count[s] = sh_count[s] - 1;
          if (sh_count[s] == 0) begin
            hit = 1;
            sh_count[s] = sh_period[s];
          end
        end
        if (hit && sh_iolen[s] != 0 && sh_remain[s] != 0) begin
          sh_phase[s] = PH_WAIT;
          sh_wstart[s] = t1;
          sh_wake[s] = t1 + 32'(sh_iolen[s]);
          sh_running = NSLOT;
          recs = {recs, mk_rec(KIND_TRANS, t1, sh_pid[s], PH_RUN, PH_WAIT, CAUSE_NONE, 0, 0)};
        end else if (sh_remain[s] == 0) begin
          sh_phase[s] = PH_TERM;
          sh_running = NSLOT;
          recs = {recs, mk_rec(KIND_TRANS, t1, sh_pid[s], PH_RUN, PH_TERM, CAUSE_NONE, 0, 0)};
        end
      end
      sh_now = sh_now + 1;
      any = 0;
      done = 1;
      for (int i = 0; i < NSLOT; i++) begin
        if (sh_used[i]) begin
          any = 1;
          if (sh_phase[i] != PH_TERM) done = 0;
        end
      end
      recs = {recs, mk_rec(KIND_SUMM, sh_now,
                           (sh_running >= NSLOT) ? 8'd0 : sh_pid[sh_running],
                           PH_NEW, PH_NEW, CAUSE_NONE, sh_running >= NSLOT, any && done)};
    end
    recs[recs.size() - 1].last = 1'b1;
    expected_records = {expected_records, recs};
  endtask

  function automatic request_t admit_req(logic [7:0] p, logic [15:0] b, logic [15:0] e,
                                         logic [15:0] l);
    request_t rq;
    rq.opcode = OP_ADMIT; rq.pid = p; rq.burst = b; rq.io_every = e; rq.io_length = l;
    return rq;
  endfunction

  function automatic request_t tick_req();
    request_t rq;
    rq.opcode = OP_TICK; rq.pid = 8'($urandom); rq.burst = 16'($urandom);
    rq.io_every = 16'($urandom); rq.io_length = 16'($urandom);
    return rq;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    request_t rq;
    int n;
    stim_done = 0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_used[i] = 0;
      sh_pid[i] = '0;
      sh_phase[i] = PH_NEW;
    end
    sh_now = '0;
    sh_running = NSLOT;
    // Directed: a tick on an empty table, zero burst, extremes, full table.
    pending_requests = {pending_requests, tick_req()};
    pending_requests = {pending_requests, admit_req(8'd255, 16'd0, 16'hFFFF, 16'hFFFF)};
    pending_requests = {pending_requests, admit_req(8'd200, 16'd3, 16'd1, 16'd2)};
    pending_requests = {pending_requests, admit_req(8'd0, 16'd1, 16'd0, 16'd0)};
    pending_requests = {pending_requests, admit_req(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF)};
    pending_requests = {pending_requests, admit_req(8'd200, 16'd4, 16'd2, 16'd0)};
    pending_requests = {pending_requests, admit_req(8'd100, 16'd5, 16'd1, 16'd1)};
    for (int i = 0; i < 8; i++) pending_requests = {pending_requests, tick_req()};
    for (int i = 0; i < 11; i++)
      pending_requests = {pending_requests,
                          admit_req(8'(i * 23), 16'(i + 1), 16'(i % 3), 16'(i % 4))};
    wait (pending_requests.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_records.size() == 0);
    // Random: mostly ticks, plus admits with zero, random or small bursts that a full table rejects.
    n = 0;
    while (n < 180) begin
      if (n == 90) begin
        wait (pending_requests.size() == 0);
        @(posedge clk);
        wait (!in_valid && expected_records.size() == 0);
      end
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: rq = admit_req(8'($urandom), 16'd0, 16'($urandom), 16'($urandom));
          1: rq = admit_req(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          default: rq = admit_req(8'($urandom), 16'($urandom_range(1, 8)),
                                  16'($urandom_range(0, 3)), 16'($urandom_range(0, 4)));
        endcase
      end else begin
        rq = tick_req();
      end
      pending_requests = {pending_requests, rq};
      n++;
    end
    stim_done = 1;
  end

  // Driver: bursts of requests separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    request_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= OP_TICK;
      in_pid <= '0;
      in_burst <= '0;
      in_io_every <= '0;
      in_io_length <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        rq.opcode = in_opcode; rq.pid = in_pid; rq.burst = in_burst;
        rq.io_every = in_io_every; rq.io_length = in_io_length;
        schedule_request(rq);
        if (rq.opcode == OP_TICK) ticks_sent++; else admits_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          rq = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_opcode <= rq.opcode;
          in_pid <= rq.pid;
          in_burst <= rq.burst;
          in_io_every <= rq.io_every;
          in_io_length <= rq.io_length;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with receiver stall pattern.
  int stall_phase;
  always @(posedge clk) begin
    record_t got;
    record_t exp_rec;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ready <= ((stall_phase % 97) < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (out_valid && out_ready) begin
        got.kind = out_kind; got.event_time = out_event_time; got.proc_id = out_proc_id;
        got.from_state = out_from_state; got.to_state = out_to_state;
        got.reject_cause = out_reject_cause; got.cpu_idle = out_cpu_idle;
        got.finished = out_finished; got.last = out_last;
        records_seen++;
        if (got.kind == KIND_REJECT) rejects_seen++;
        if (got.kind == KIND_TRANS && got.to_state == PH_WAIT) waits_seen++;
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: kind %0d pid %0d t %0d", got.kind, got.proc_id,
                     got.event_time);
        end else begin
          exp_rec = expected_records.pop_front();
          if (got !== exp_rec) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch exp: k%0d t%0d p%0d %0d->%0d c%0d i%0d d%0d l%0d",
                       exp_rec.kind, exp_rec.event_time, exp_rec.proc_id,
                       exp_rec.from_state, exp_rec.to_state, exp_rec.reject_cause,
                       exp_rec.cpu_idle, exp_rec.finished, exp_rec.last);
              $display("         got: k%0d t%0d p%0d %0d->%0d c%0d i%0d d%0d l%0d",
                       got.kind, got.event_time, got.proc_id, got.from_state,
                       got.to_state, got.reject_cause, got.cpu_idle, got.finished,
                       got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout with %0d results outstanding.", expected_records.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done && pending_requests.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_records.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d admits and %0d ticks; checked %0d results.", admits_sent,
             ticks_sent, records_seen);
    $display("Saw %0d rejected admits and %0d I/O waits.", rejects_seen, waits_seen);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcs_pkg.sv
rtl/pcs_ctrl.sv
rtl/pcs_dpath.sv
rtl/priority_cpu_scheduler_with_io.sv
verif/tb_top.sv
